FILE: rtl/core/sc_pkg.sv
// ----------------------------------------------------------------------------
// sc_pkg
// Shared widths, payload structs and sequencer states for the stress
// centrality unit.
// ----------------------------------------------------------------------------
package sc_pkg;

  localparam int MAX_NODES = 64;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = 2 ** ADDR_W;

  localparam int NODE_W  = 6;
  localparam int NC_W    = 7;
  localparam int DIST_W  = 16;
  localparam int CNT_W   = 32;
  localparam int ACC_W   = 64;

  localparam logic [NC_W-1:0] NC_RESET = NC_W'(64);

  typedef struct packed {
    logic [NODE_W-1:0] row;
    logic [NODE_W-1:0] col;
    logic [DIST_W-1:0] distance;
    logic [CNT_W-1:0]  path_count;
    logic              last;
  } sc_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [ACC_W-1:0]  stress;
    logic              last_result;
  } sc_out_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] addr_c;
  } sc_rd_req_t;

  typedef struct packed {
    logic latch_row;
    logic issue;
    logic clear;
  } sc_mac_ctrl_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ROW,
    ST_ROWW,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH,
    ST_EMIT
  } sc_state_e;

endpackage

FILE: rtl/core/sc_store.sv
// ----------------------------------------------------------------------------
// sc_store
// Distance and path count matrices: one write port, registered reads
// (two on the distance matrix, one on the count matrix).
// ----------------------------------------------------------------------------
module sc_store
  import sc_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DIST_W-1:0] wdist_i,
  input  logic [CNT_W-1:0]  wcnt_i,
  input  sc_rd_req_t        rd_i,
  output logic [DIST_W-1:0] dist_a_o,
  output logic [DIST_W-1:0] dist_b_o,
  output logic [CNT_W-1:0]  cnt_o
);

  logic [DIST_W-1:0] dist_mem [DEPTH];
  logic [CNT_W-1:0]  cnt_mem  [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      dist_mem[waddr_i] <= wdist_i;
      cnt_mem[waddr_i]  <= wcnt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_a_o <= dist_mem[rd_i.addr_a];
    dist_b_o <= dist_mem[rd_i.addr_b];
    cnt_o    <= cnt_mem[rd_i.addr_c];
  end

endmodule

FILE: rtl/core/sc_mac.sv
// ----------------------------------------------------------------------------
// sc_mac
// Shared path test and multiply-accumulate: saturating distance compare,
// 32x32 product, saturating 64-bit accumulate.
// ----------------------------------------------------------------------------
module sc_mac
  import sc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sc_mac_ctrl_t      ctrl_i,
  input  logic [DIST_W-1:0] dist_a_i,
  input  logic [DIST_W-1:0] dist_b_i,
  input  logic [CNT_W-1:0]  cnt_i,
  output logic [ACC_W-1:0]  acc_o
);

  logic [DIST_W-1:0] dji_q;
  logic [CNT_W-1:0]  cji_q;
  logic              v1_q;
  logic              pv_q, pv_d;
  logic [ACC_W-1:0]  prod_q, prod_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [DIST_W:0]   via_sum;
  logic [DIST_W-1:0] via_sat;
  logic [ACC_W:0]    acc_sum;

  always_comb begin
    via_sum = {1'b0, dji_q} + {1'b0, dist_a_i};
    via_sat = via_sum[DIST_W] ? '1 : via_sum[DIST_W-1:0];
    pv_d    = v1_q && (dist_b_i >= via_sat);
    prod_d  = {{(ACC_W-CNT_W){1'b0}}, cji_q} * {{(ACC_W-CNT_W){1'b0}}, cnt_i};
    acc_sum = {1'b0, acc_q} + {1'b0, prod_q};
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (pv_q) begin
      acc_d = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_row) begin
      dji_q <= dist_a_i;
      cji_q <= cnt_i;
    end
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      pv_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      v1_q  <= ctrl_i.issue;
      pv_q  <= pv_d;
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

  a_acc_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.clear |=> acc_q >= $past(acc_q))
    else $error("accumulator went down without clear");

  a_prod_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> $past(v1_q))
    else $error("product valid without issued read");

endmodule

FILE: rtl/core/sc_ctrl.sv
// ----------------------------------------------------------------------------
// sc_ctrl
// Sequencer: load phase, then walks node triples (i, j, k), one k per
// cycle, and hands out one result per node.
// ----------------------------------------------------------------------------
module sc_ctrl
  import sc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  input  logic [NC_W-1:0]   cfg_n_i,
  input  logic              out_ready_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output logic [NODE_W-1:0] node_o,
  output logic              last_o,
  output sc_rd_req_t        rd_o,
  output sc_mac_ctrl_t      mac_o
);

  sc_state_e       state_q, state_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [NC_W-1:0]  n_q, n_d, n_start, n_m1;
  logic             i_last, j_last, k_last;

  assign n_start = (cfg_n_i > NC_W'(MAX_NODES)) ? NC_W'(MAX_NODES) : cfg_n_i;
  assign n_m1    = n_q - 1'b1;
  assign i_last  = NC_W'(i_q) == n_m1;
  assign j_last  = NC_W'(j_q) == n_m1;
  assign k_last  = NC_W'(k_q) == n_m1;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    n_d     = n_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i && in_last_i) begin
          n_d = n_start;
          i_d = '0;
          j_d = '0;
          if (n_start != '0) state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        if (j_q == i_q) begin
          if (j_last) state_d = ST_DRAIN;
          else j_d = j_q + 1'b1;
        end else begin
          state_d = ST_ROWW;
        end
      end
      ST_ROWW: begin
        k_d     = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (k_last) begin
          if (j_last) begin
            state_d = ST_DRAIN;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = ST_ROW;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DRAIN: state_d = ST_FLUSH;
      ST_FLUSH: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_ready_i) begin
          if (i_last) begin
            state_d = ST_LOAD;
          end else begin
            i_d     = i_q + 1'b1;
            j_d     = '0;
            state_d = ST_ROW;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready_o      = state_q == ST_LOAD;
    out_valid_o     = state_q == ST_EMIT;
    node_o          = NODE_W'(i_q);
    last_o          = i_last;
    rd_o.addr_a     = {i_q, k_q};
    rd_o.addr_b     = {j_q, k_q};
    rd_o.addr_c     = {i_q, k_q};
    mac_o.latch_row = state_q == ST_ROWW;
    mac_o.issue     = (state_q == ST_SCAN) && (k_q != i_q) && (k_q != j_q);
    mac_o.clear     = (state_q == ST_LOAD) || ((state_q == ST_EMIT) && out_ready_i);
    if (state_q == ST_ROW) begin
      rd_o.addr_a = {j_q, i_q};
      rd_o.addr_c = {j_q, i_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      n_q     <= n_d;
    end
  end

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (NC_W'(i_q) < n_q) && (NC_W'(j_q) < n_q)
                             && (NC_W'(k_q) < n_q) && (i_q != j_q))
    else $error("triple walk out of range");

  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> $past(state_q == ST_FLUSH) || $past(state_q == ST_EMIT))
    else $error("result shown before pipeline drained");

endmodule

FILE: rtl/core/stress_centrality_unit.sv
// ----------------------------------------------------------------------------
// stress_centrality_unit
// Shimbel stress centrality over a loaded all-pairs distance / count matrix.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o / in_req_i): one matrix entry per
// request, one request per cycle while loading. An entry with last set is
// stored and then starts the computation (none if node_count is 0);
// in_ready_o stays low until the final result has been taken.
// Output channel (out_valid_o / out_ready_i / out_rsp_o): one result per
// node, nodes in increasing order, last_result set on the highest node.
// node_count is written through cfg_we_i / cfg_wdata_i while idle.
// Timing: per node, each j != i fetches a row (ST_ROW, ST_ROWW), then scans
// one k per cycle through the shared compare / multiply / accumulate unit,
// fed by the matrix read ports; j == i is skipped, and drain and result close
// each node. A stalled receiver holds the result and the walk.
// Reset: node_count returns to 64, the sequencer goes to loading; the
// matrices keep their contents and must be written before they are read.
// ----------------------------------------------------------------------------
module stress_centrality_unit
  import sc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sc_in_t          in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sc_out_t         out_rsp_o,
  input  logic            cfg_we_i,
  input  logic [NC_W-1:0] cfg_wdata_i
);

  logic [NC_W-1:0]   node_count_q;
  logic              we;
  logic [DIST_W-1:0] dist_a, dist_b;
  logic [CNT_W-1:0]  cnt;
  logic [ACC_W-1:0]  acc;
  sc_rd_req_t        rd_req;
  sc_mac_ctrl_t      mac_ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NC_RESET;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  assign we = in_valid_i && in_ready_o && (int'(in_req_i.row) < MAX_NODES)
              && (int'(in_req_i.col) < MAX_NODES);

  sc_store u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  ({in_req_i.row[IDX_W-1:0], in_req_i.col[IDX_W-1:0]}),
    .wdist_i  (in_req_i.distance),
    .wcnt_i   (in_req_i.path_count),
    .rd_i     (rd_req),
    .dist_a_o (dist_a),
    .dist_b_o (dist_b),
    .cnt_o    (cnt)
  );

  sc_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .dist_a_i (dist_a),
    .dist_b_i (dist_b),
    .cnt_i    (cnt),
    .acc_o    (acc)
  );

  sc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_req_i.last),
    .cfg_n_i     (node_count_q),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .node_o      (out_rsp_o.node),
    .last_o      (out_rsp_o.last_result),
    .rd_o        (rd_req),
    .mac_o       (mac_ctrl)
  );

  assign out_rsp_o.stress = acc;

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("loading and result at once");

endmodule
